// File: design/ddpd_pkg.sv
// Shared types and constants for the differential drive PD velocity block.
// Used by the serial divider, the serial multiplier, the top level and the checker.
`timescale 1ns / 1ps

package ddpd_pkg;

	// configuration port
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_TGT_FWD   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TGT_ROT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_FWD_KP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_FWD_KD    = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROT_KP    = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROT_KD    = 3'd5;
	localparam logic [IDX_W-1:0] REG_PERIOD    = 3'd6;
	localparam logic [IDX_W-1:0] REG_PWM_LIMIT = 3'd7;

	// field widths
	localparam int COUNT_W  = 32;
	localparam int TGT_W    = 24;
	localparam int GAIN_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int LIMIT_W  = 15;
	localparam int DRIVE_W  = 16;

	// reset values of the registers
	localparam logic [GAIN_W-1:0]   FWD_KP_RST  = 16'd3072;
	localparam logic [GAIN_W-1:0]   ROT_KP_RST  = 16'd4096;
	localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd10;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 15'd255;

	// arithmetic
	localparam int SPEED_W   = 33;  // sum or difference of two deltas
	localparam int DIVIDEND_W = 42; // |speed| * 1000 < 2^42
	localparam int MCAND_W   = 33;  // error or error change
	localparam int PROD_W    = MCAND_W + 1 + GAIN_W;
	localparam int GAIN_FRAC = 12;

	localparam int DIV_STEPS = DIVIDEND_W;
	localparam int MUL_STEPS = GAIN_W;
	localparam int CNT_W     = 6;

	// control of a serial unit
	typedef struct packed {
		logic load;
		logic step;
	} ddpd_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_ABS,
		ST_TRIPLE,
		ST_SCALE,
		ST_DIV,
		ST_FB,
		ST_ERR,
		ST_DERR,
		ST_MUL,
		ST_SUM,
		ST_ROUND,
		ST_MIX
	} ddpd_state_t;

endpackage

// File: design/ddpd_sdiv.sv
// Restoring divider, one quotient bit per step: unsigned dividend by nonzero divisor.
// Depends on ddpd_pkg for widths and the step control struct.
`timescale 1ns / 1ps

module ddpd_sdiv import ddpd_pkg::*; (
	input  logic                  clk,
	input  ddpd_step_t            ctl,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [PERIOD_W-1:0]   divisor,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [DIVIDEND_W-1:0] rq_q;   // dividend bits shift out, quotient bits shift in
	logic [PERIOD_W-1:0]   rem_q;
	logic [PERIOD_W-1:0]   dvs_q;
	logic [PERIOD_W:0]     trial;
	logic [PERIOD_W:0]     diff;
	logic                  ge;

	always_comb begin
		trial = {rem_q, rq_q[DIVIDEND_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (ctl.step) begin
			rq_q  <= {rq_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
		end
	end

	assign quotient = rq_q;

endmodule

// File: design/ddpd_smul.sv
// Shift-add multiplier, one gain bit per step: unsigned gain times signed operand.
// Depends on ddpd_pkg for widths and the step control struct.
`timescale 1ns / 1ps

module ddpd_smul import ddpd_pkg::*; (
	input  logic                     clk,
	input  ddpd_step_t               ctl,
	input  logic [GAIN_W-1:0]        gain,
	input  logic signed [MCAND_W-1:0] mcand,
	output logic signed [PROD_W-1:0]  product
);

	logic signed [MCAND_W-1:0] m_q;
	logic [GAIN_W-1:0]         b_q;
	logic signed [MCAND_W:0]   hi_q;   // upper partial product, |hi| <= |m|
	logic [GAIN_W-1:0]         lo_q;   // finished low bits
	logic signed [MCAND_W:0]   sum;

	always_comb begin
		sum = hi_q + (b_q[0] ? {m_q[MCAND_W-1], m_q} : '0);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			m_q  <= mcand;
			b_q  <= gain;
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctl.step) begin
			b_q  <= {1'b0, b_q[GAIN_W-1:1]};
			hi_q <= {sum[MCAND_W], sum[MCAND_W:1]};
			lo_q <= {sum[0], lo_q[GAIN_W-1:1]};
		end
	end

	assign product = {hi_q, lo_q};

endmodule

// File: design/differential_drive_pd_velocity_top.sv
// Top level of the differential drive PD velocity controller.
// Depends on ddpd_pkg, ddpd_sdiv and ddpd_smul.
`timescale 1ns / 1ps

// Usage
// Each input item carries the absolute left and right encoder counts of one control
// tick; the block answers each with one item holding the signed left and right drive
// commands and a flag that is set when any value was clipped along the way.
// Both channels use valid/ready. Registers are written through cfg_we, cfg_index and
// cfg_wdata, by the user only while no item is in flight; the block does not check.
// Flow: an accepted item passes the 42-step bit-serial divider that scales the
// speeds by 1000 / period_ms, the 16-step bit-serial gain multipliers, ten add and
// saturate steps and the idle state that takes the item. in_ready returns in the
// cycle the result first shows, so the block takes no new item while one is in
// flight; items are handled one at a time.
// The result sits in an output register; a new item is accepted while it waits.
// When the receiver stalls and a second result is finished, the block holds it in
// its last step and takes no new item until the output register frees.
// Reset sets the registers to their defaults (kp 0.75 forward, 1.0 rotation,
// period 10 ms, limit 255) and clears the stored counts and previous errors.

module differential_drive_pd_velocity_top import ddpd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COUNT_W-1:0] left_count,
	input  logic signed [COUNT_W-1:0] right_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] left_drive,
	output logic signed [DRIVE_W-1:0] right_drive,
	output logic                      saturated
);

	// registers
	logic signed [TGT_W-1:0] tgt_x_q, tgt_w_q;
	logic [GAIN_W-1:0]       kp_x_q, kd_x_q, kp_w_q, kd_w_q;
	logic [PERIOD_W-1:0]     period_q;
	logic [LIMIT_W-1:0]      limit_q;

	// state across ticks
	logic [COUNT_W-1:0]        last_l_q, last_r_q;
	logic signed [COUNT_W-1:0] last_err_x_q, last_err_w_q;

	ddpd_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             flag_q;
	logic             accept;
	logic             out_load;
	ddpd_step_t       div_ctl, mul_ctl;

	// datapath
	logic [COUNT_W-1:0]        dl_q, dr_q;
	logic signed [SPEED_W-1:0] spd_x_q, spd_w_q;
	logic                      neg_x_q, neg_w_q;
	logic [SPEED_W-1:0]        mag_x_q, mag_w_q;
	logic [SPEED_W+1:0]        tri_x_q, tri_w_q;
	logic [DIVIDEND_W-1:0]     scl_x, scl_w;
	logic [DIVIDEND_W-1:0]     quo_x, quo_w;
	logic [PERIOD_W-1:0]       divisor;
	logic signed [COUNT_W-1:0] fb_x_q, fb_w_q;
	logic signed [COUNT_W-1:0] fb_x, fb_w;
	logic                      fb_x_sat, fb_w_sat;
	logic signed [SPEED_W-1:0] e_x, e_w;
	logic signed [COUNT_W-1:0] err_x_q, err_w_q;
	logic signed [MCAND_W-1:0] derr_x, derr_w;
	logic signed [PROD_W-1:0]  pkp_x, pkd_x, pkp_w, pkd_w;
	logic signed [PROD_W-1:0]  acc_x_q, acc_w_q;
	logic signed [PROD_W-1:0]  rnd_x, rnd_w;
	logic signed [PROD_W-GAIN_FRAC-1:0] shr_x, shr_w;
	logic                      pd_x_sat, pd_w_sat;
	logic signed [COUNT_W-1:0] pwm_x_q, pwm_w_q;
	logic signed [SPEED_W-1:0] lim, mix_l, mix_r;
	logic signed [SPEED_W-1:0] drv_l, drv_r;
	logic                      clip_l, clip_r;

	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] left_q, right_q;
	logic                      sat_q;

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		div_ctl  = '0;
		mul_ctl  = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA:  state_d = ST_ABS;
			ST_ABS:    state_d = ST_TRIPLE;
			ST_TRIPLE: state_d = ST_SCALE;
			ST_SCALE: begin
				div_ctl.load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				div_ctl.step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FB;
				end
			end
			ST_FB:  state_d = ST_ERR;
			ST_ERR: state_d = ST_DERR;
			ST_DERR: begin
				mul_ctl.load = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				mul_ctl.step = 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM:   state_d = ST_ROUND;
			ST_ROUND: state_d = ST_MIX;
			ST_MIX: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	// control registers, configuration and state kept across ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q      <= '0;
			tgt_w_q      <= '0;
			kp_x_q       <= FWD_KP_RST;
			kd_x_q       <= '0;
			kp_w_q       <= ROT_KP_RST;
			kd_w_q       <= '0;
			period_q     <= PERIOD_RST;
			limit_q      <= LIMIT_RST;
			last_l_q     <= '0;
			last_r_q     <= '0;
			last_err_x_q <= '0;
			last_err_w_q <= '0;
			cnt_q        <= '0;
			flag_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TGT_FWD:   tgt_x_q  <= cfg_wdata[TGT_W-1:0];
					REG_TGT_ROT:   tgt_w_q  <= cfg_wdata[TGT_W-1:0];
					REG_FWD_KP:    kp_x_q   <= cfg_wdata[GAIN_W-1:0];
					REG_FWD_KD:    kd_x_q   <= cfg_wdata[GAIN_W-1:0];
					REG_ROT_KP:    kp_w_q   <= cfg_wdata[GAIN_W-1:0];
					REG_ROT_KD:    kd_w_q   <= cfg_wdata[GAIN_W-1:0];
					REG_PERIOD:    period_q <= cfg_wdata[PERIOD_W-1:0];
					REG_PWM_LIMIT: limit_q  <= cfg_wdata[LIMIT_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				last_l_q <= left_count;
				last_r_q <= right_count;
			end
			if (state_q == ST_DERR) begin
				last_err_x_q <= err_x_q;
				last_err_w_q <= err_w_q;
			end

			if (state_q == ST_DIV || state_q == ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end

			case (state_q)
				ST_IDLE:  if (accept) flag_q <= 1'b0;
				ST_FB:    flag_q <= flag_q | fb_x_sat | fb_w_sat;
				ST_ERR:   flag_q <= flag_q | (e_x[SPEED_W-1] != e_x[SPEED_W-2])
				                           | (e_w[SPEED_W-1] != e_w[SPEED_W-2]);
				ST_ROUND: flag_q <= flag_q | pd_x_sat | pd_w_sat;
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// speed scaling: |speed| * 1000 = |speed| * 1024 - (|speed| * 3) * 8
	assign scl_x = DIVIDEND_W'({mag_x_q, 10'd0} - {5'd0, tri_x_q, 3'd0});
	assign scl_w = DIVIDEND_W'({mag_w_q, 10'd0} - {5'd0, tri_w_q, 3'd0});
	assign divisor = (period_q == '0) ? PERIOD_W'(1) : period_q;

	ddpd_sdiv u_div_x (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (scl_x),
		.divisor  (divisor),
		.quotient (quo_x)
	);

	ddpd_sdiv u_div_w (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (scl_w),
		.divisor  (divisor),
		.quotient (quo_w)
	);

	// signed feedback from quotient magnitude, saturated to 32 bits
	always_comb begin
		fb_x_sat = 1'b0;
		fb_x     = -$signed(quo_x[COUNT_W-1:0]);
		if (neg_x_q) begin
			if ((|quo_x[DIVIDEND_W-1:COUNT_W]) ||
			    (quo_x[COUNT_W-1] && (|quo_x[COUNT_W-2:0]))) begin
				fb_x_sat = 1'b1;
				fb_x     = {1'b1, {(COUNT_W-1){1'b0}}};
			end
		end else begin
			fb_x = $signed(quo_x[COUNT_W-1:0]);
			if (|quo_x[DIVIDEND_W-1:COUNT_W-1]) begin
				fb_x_sat = 1'b1;
				fb_x     = {1'b0, {(COUNT_W-1){1'b1}}};
			end
		end

		fb_w_sat = 1'b0;
		fb_w     = -$signed(quo_w[COUNT_W-1:0]);
		if (neg_w_q) begin
			if ((|quo_w[DIVIDEND_W-1:COUNT_W]) ||
			    (quo_w[COUNT_W-1] && (|quo_w[COUNT_W-2:0]))) begin
				fb_w_sat = 1'b1;
				fb_w     = {1'b1, {(COUNT_W-1){1'b0}}};
			end
		end else begin
			fb_w = $signed(quo_w[COUNT_W-1:0]);
			if (|quo_w[DIVIDEND_W-1:COUNT_W-1]) begin
				fb_w_sat = 1'b1;
				fb_w     = {1'b0, {(COUNT_W-1){1'b1}}};
			end
		end
	end

	// error against target
	assign e_x = {{(SPEED_W-TGT_W){tgt_x_q[TGT_W-1]}}, tgt_x_q} - {fb_x_q[COUNT_W-1], fb_x_q};
	assign e_w = {{(SPEED_W-TGT_W){tgt_w_q[TGT_W-1]}}, tgt_w_q} - {fb_w_q[COUNT_W-1], fb_w_q};

	assign derr_x = {err_x_q[COUNT_W-1], err_x_q} - {last_err_x_q[COUNT_W-1], last_err_x_q};
	assign derr_w = {err_w_q[COUNT_W-1], err_w_q} - {last_err_w_q[COUNT_W-1], last_err_w_q};

	ddpd_smul u_mul_kp_x (
		.clk     (clk),
		.ctl     (mul_ctl),
		.gain    (kp_x_q),
		.mcand   ({err_x_q[COUNT_W-1], err_x_q}),
		.product (pkp_x)
	);

	ddpd_smul u_mul_kd_x (
		.clk     (clk),
		.ctl     (mul_ctl),
		.gain    (kd_x_q),
		.mcand   (derr_x),
		.product (pkd_x)
	);

	ddpd_smul u_mul_kp_w (
		.clk     (clk),
		.ctl     (mul_ctl),
		.gain    (kp_w_q),
		.mcand   ({err_w_q[COUNT_W-1], err_w_q}),
		.product (pkp_w)
	);

	ddpd_smul u_mul_kd_w (
		.clk     (clk),
		.ctl     (mul_ctl),
		.gain    (kd_w_q),
		.mcand   (derr_w),
		.product (pkd_w)
	);

	// divide by 4096 toward zero, then saturate
	always_comb begin
		rnd_x = acc_x_q + (acc_x_q[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC) - 1) : '0);
		rnd_w = acc_w_q + (acc_w_q[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC) - 1) : '0);
		shr_x = rnd_x[PROD_W-1:GAIN_FRAC];
		shr_w = rnd_w[PROD_W-1:GAIN_FRAC];
		pd_x_sat = !((&shr_x[PROD_W-GAIN_FRAC-1:COUNT_W-1]) ||
		             !(|shr_x[PROD_W-GAIN_FRAC-1:COUNT_W-1]));
		pd_w_sat = !((&shr_w[PROD_W-GAIN_FRAC-1:COUNT_W-1]) ||
		             !(|shr_w[PROD_W-GAIN_FRAC-1:COUNT_W-1]));
	end

	// wheel mixing and clipping
	always_comb begin
		lim   = $signed({{(SPEED_W-LIMIT_W){1'b0}}, limit_q});
		mix_l = {pwm_x_q[COUNT_W-1], pwm_x_q} - {pwm_w_q[COUNT_W-1], pwm_w_q};
		mix_r = {pwm_x_q[COUNT_W-1], pwm_x_q} + {pwm_w_q[COUNT_W-1], pwm_w_q};
		drv_l  = mix_l;
		clip_l = 1'b0;
		if (mix_l > lim) begin
			drv_l  = lim;
			clip_l = 1'b1;
		end else if (mix_l < -lim) begin
			drv_l  = -lim;
			clip_l = 1'b1;
		end
		drv_r  = mix_r;
		clip_r = 1'b0;
		if (mix_r > lim) begin
			drv_r  = lim;
			clip_r = 1'b1;
		end else if (mix_r < -lim) begin
			drv_r  = -lim;
			clip_r = 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dl_q <= left_count - last_l_q;
				dr_q <= right_count - last_r_q;
			end
			ST_DELTA: begin
				spd_x_q <= {dr_q[COUNT_W-1], dr_q} + {dl_q[COUNT_W-1], dl_q};
				spd_w_q <= {dr_q[COUNT_W-1], dr_q} - {dl_q[COUNT_W-1], dl_q};
			end
			ST_ABS: begin
				neg_x_q <= spd_x_q[SPEED_W-1];
				neg_w_q <= spd_w_q[SPEED_W-1];
				mag_x_q <= spd_x_q[SPEED_W-1] ? -spd_x_q : spd_x_q;
				mag_w_q <= spd_w_q[SPEED_W-1] ? -spd_w_q : spd_w_q;
			end
			ST_TRIPLE: begin
				tri_x_q <= {2'b0, mag_x_q} + {1'b0, mag_x_q, 1'b0};
				tri_w_q <= {2'b0, mag_w_q} + {1'b0, mag_w_q, 1'b0};
			end
			ST_FB: begin
				fb_x_q <= fb_x;
				fb_w_q <= fb_w;
			end
			ST_ERR: begin
				if (e_x[SPEED_W-1] != e_x[SPEED_W-2]) begin
					err_x_q <= e_x[SPEED_W-1] ? {1'b1, {(COUNT_W-1){1'b0}}}
					                          : {1'b0, {(COUNT_W-1){1'b1}}};
				end else begin
					err_x_q <= e_x[COUNT_W-1:0];
				end
				if (e_w[SPEED_W-1] != e_w[SPEED_W-2]) begin
					err_w_q <= e_w[SPEED_W-1] ? {1'b1, {(COUNT_W-1){1'b0}}}
					                          : {1'b0, {(COUNT_W-1){1'b1}}};
				end else begin
					err_w_q <= e_w[COUNT_W-1:0];
				end
			end
			ST_SUM: begin
				acc_x_q <= pkp_x + pkd_x;
				acc_w_q <= pkp_w + pkd_w;
			end
			ST_ROUND: begin
				if (pd_x_sat) begin
					pwm_x_q <= shr_x[PROD_W-GAIN_FRAC-1] ? {1'b1, {(COUNT_W-1){1'b0}}}
					                                      : {1'b0, {(COUNT_W-1){1'b1}}};
				end else begin
					pwm_x_q <= shr_x[COUNT_W-1:0];
				end
				if (pd_w_sat) begin
					pwm_w_q <= shr_w[PROD_W-GAIN_FRAC-1] ? {1'b1, {(COUNT_W-1){1'b0}}}
					                                      : {1'b0, {(COUNT_W-1){1'b1}}};
				end else begin
					pwm_w_q <= shr_w[COUNT_W-1:0];
				end
			end
			default: ;
		endcase

		if (out_load) begin
			left_q  <= drv_l[DRIVE_W-1:0];
			right_q <= drv_r[DRIVE_W-1:0];
			sat_q   <= flag_q | clip_l | clip_r;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign saturated   = sat_q;

endmodule

// File: design/ddpd_chk.sv
// Port-level checker for the differential drive PD velocity top level, with its bind.
// Depends on ddpd_pkg for the register index and field widths.
`timescale 1ns / 1ps

module ddpd_chk import ddpd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input logic [IDX_W-1:0]          cfg_index,
	input logic [CFG_W-1:0]          cfg_wdata,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [DRIVE_W-1:0] left_drive,
	input logic signed [DRIVE_W-1:0] right_drive,
	input logic                      saturated
);

	logic [LIMIT_W-1:0]      lim_q;
	logic signed [DRIVE_W:0] lim_pos, lim_neg, l_ext, r_ext;

	// shadow of the drive limit as written through the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_RST;
		end else if (cfg_we && cfg_index == REG_PWM_LIMIT) begin
			lim_q <= cfg_wdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		lim_pos = $signed({2'b0, lim_q});
		lim_neg = -lim_pos;
		l_ext   = {left_drive[DRIVE_W-1], left_drive};
		r_ext   = {right_drive[DRIVE_W-1], right_drive};
	end

	// one item at a time: no second item right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted item");

	// a result never shows in the cycle after an item enters
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after accept");

	// drives stay inside the configured limit
	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (l_ext <= lim_pos) && (l_ext >= lim_neg) &&
		              (r_ext <= lim_pos) && (r_ext >= lim_neg))
		else $error("drive outside the configured limit");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive) &&
		                             $stable(right_drive) && $stable(saturated))
		else $error("stalled result changed");

endmodule

bind differential_drive_pd_velocity_top ddpd_chk u_ddpd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.cfg_wdata   (cfg_wdata),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_drive  (left_drive),
	.right_drive (right_drive),
	.saturated   (saturated)
);

// File: bench/tb.sv
// Self-checking bench for differential_drive_pd_velocity_top: wheel drives checked
// against a tick-by-tick PD predictor kept inside the bench. Depends on ddpd_pkg.
`timescale 1ns / 1ps

module tb import ddpd_pkg::*; ();

	localparam int     CYCLE_LIMIT = 1_000_000;
	localparam int     SEG_ITEMS   = 50;
	localparam int     SEGMENTS    = 11;
	localparam longint SPEED_SCALE = 1000;
	localparam longint GAIN_ONE    = longint'(1) << GAIN_FRAC;
	localparam longint WORD_MAX    = 64'sd2147483647;
	localparam longint WORD_MIN    = -64'sd2147483648;

	typedef struct packed {
		logic [DRIVE_W-1:0] left;
		logic [DRIVE_W-1:0] right;
		logic               clipped;
	} drive_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]          cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [COUNT_W-1:0] left_count = '0;
	logic signed [COUNT_W-1:0] right_count = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic                      saturated;

	// controller registers as the predictor sees them
	logic signed [TGT_W-1:0] tgt_fwd, tgt_rot;
	logic [GAIN_W-1:0]       fwd_kp, fwd_kd, rot_kp, rot_kd;
	logic [PERIOD_W-1:0]     period;
	logic [LIMIT_W-1:0]      drive_limit;

	// tick history
	logic [COUNT_W-1:0] prev_left, prev_right;
	longint             prev_fwd_err, prev_rot_err;
	bit                 pred_clipped;

	logic [COUNT_W-1:0] sent_left = '0;
	logic [COUNT_W-1:0] sent_right = '0;
	drive_t             drive_q[$];
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 mismatch_cnt = 0;
	int                 cycle_cnt = 0;

	differential_drive_pd_velocity_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_count (left_count),
		.right_count(right_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.left_drive (left_drive),
		.right_drive(right_drive),
		.saturated  (saturated)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint sat_word(longint v);
		if (v > WORD_MAX) begin
			pred_clipped = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			pred_clipped = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	function automatic longint clip_drive(longint v);
		longint lim;
		lim = longint'(drive_limit);
		if (v > lim) begin
			pred_clipped = 1'b1;
			return lim;
		end
		if (v < -lim) begin
			pred_clipped = 1'b1;
			return -lim;
		end
		return v;
	endfunction

	function automatic longint pd_law(longint err, longint prev, longint kp, longint kd);
		longint acc;
		acc = kp * err + kd * (err - prev);
		return sat_word(acc / GAIN_ONE);
	endfunction

	task automatic load_reset_values();
		tgt_fwd      = '0;
		tgt_rot      = '0;
		fwd_kp       = FWD_KP_RST;
		fwd_kd       = '0;
		rot_kp       = ROT_KP_RST;
		rot_kd       = '0;
		period       = PERIOD_RST;
		drive_limit  = LIMIT_RST;
		prev_left    = '0;
		prev_right   = '0;
		prev_fwd_err = 0;
		prev_rot_err = 0;
	endtask

	task automatic predict_tick(input logic [COUNT_W-1:0] lc, input logic [COUNT_W-1:0] rc);
		logic [COUNT_W-1:0] dl_w, dr_w;
		longint dl, dr, per, fb_x, fb_w, err_x, err_w, pwm_x, pwm_w, l, r;
		drive_t want;
		pred_clipped = 1'b0;
		// deltas wrap modulo 2^32 and read as signed
		dl_w = lc - prev_left;
		dr_w = rc - prev_right;
		dl = longint'($signed(dl_w));
		dr = longint'($signed(dr_w));
		prev_left  = lc;
		prev_right = rc;
		per = (period == '0) ? 1 : longint'(period);
		fb_x = sat_word(((dr + dl) * SPEED_SCALE) / per);
		fb_w = sat_word(((dr - dl) * SPEED_SCALE) / per);
		err_x = sat_word(longint'(tgt_fwd) - fb_x);
		err_w = sat_word(longint'(tgt_rot) - fb_w);
		pwm_x = pd_law(err_x, prev_fwd_err, longint'(fwd_kp), longint'(fwd_kd));
		pwm_w = pd_law(err_w, prev_rot_err, longint'(rot_kp), longint'(rot_kd));
		prev_fwd_err = err_x;
		prev_rot_err = err_w;
		l = clip_drive(pwm_x - pwm_w);
		r = clip_drive(pwm_x + pwm_w);
		want.left    = l[DRIVE_W-1:0];
		want.right   = r[DRIVE_W-1:0];
		want.clipped = pred_clipped;
		drive_q.push_back(want);
	endtask

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : check_drive
		drive_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t unexpected item: expected none actual %0d %0d %0b", $time,
					left_drive, right_drive, saturated);
			end else begin
				want = drive_q.pop_front();
				if (left_drive !== want.left) begin
					mismatch_cnt++;
					$display("%0t left_drive expected %0d actual %0d", $time,
						$signed(want.left), left_drive);
				end
				if (right_drive !== want.right) begin
					mismatch_cnt++;
					$display("%0t right_drive expected %0d actual %0d", $time,
						$signed(want.right), right_drive);
				end
				if (saturated !== want.clipped) begin
					mismatch_cnt++;
					$display("%0t saturated expected %0b actual %0b", $time,
						want.clipped, saturated);
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// called at a falling edge, returns at the next falling edge
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			REG_TGT_FWD:   tgt_fwd     = val[TGT_W-1:0];
			REG_TGT_ROT:   tgt_rot     = val[TGT_W-1:0];
			REG_FWD_KP:    fwd_kp      = val[GAIN_W-1:0];
			REG_FWD_KD:    fwd_kd      = val[GAIN_W-1:0];
			REG_ROT_KP:    rot_kp      = val[GAIN_W-1:0];
			REG_ROT_KD:    rot_kd      = val[GAIN_W-1:0];
			REG_PERIOD:    period      = val[PERIOD_W-1:0];
			REG_PWM_LIMIT: drive_limit = val[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic push_counts(input logic [COUNT_W-1:0] lc, input logic [COUNT_W-1:0] rc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		left_count  = lc;
		right_count = rc;
		do @(posedge clk); while (!in_ready);
		predict_tick(lc, rc);
		sent_left  = lc;
		sent_right = rc;
		@(negedge clk);
	endtask

	// wait until every drive item has come back and the block is idle
	task automatic settle();
		in_valid = 1'b0;
		while (drive_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// ---------------------------------------------------------------- random helpers

	function automatic logic [31:0] rand_mag(int w);
		int k;
		k = $urandom_range(w);
		return $urandom & ((32'd1 << k) - 1);
	endfunction

	function automatic logic [CFG_W-1:0] rand_target();
		logic [31:0] v;
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			default: begin
				v = rand_mag(22);
				if ($urandom_range(1)) v = -v;
				return v[CFG_W-1:0];
			end
		endcase
	endfunction

	// upper bits carry junk that the register must drop
	function automatic logic [CFG_W-1:0] rand_gain();
		logic [7:0]  junk;
		logic [15:0] g;
		junk = 8'($urandom);
		case ($urandom_range(7))
			0: g = '0;
			1: g = 16'hFFFF;
			default: g = 16'(rand_mag(16));
		endcase
		return {junk, g};
	endfunction

	function automatic logic [CFG_W-1:0] rand_period();
		logic [7:0]  junk;
		logic [15:0] p;
		junk = 8'($urandom);
		case ($urandom_range(9))
			0: p = '0;
			1: p = 16'd1;
			2: p = 16'hFFFF;
			3: p = 16'(rand_mag(16));
			default: p = 16'($urandom_range(50, 1));
		endcase
		return {junk, p};
	endfunction

	function automatic logic [CFG_W-1:0] rand_limit();
		logic [8:0]  junk;
		logic [14:0] m;
		junk = 9'($urandom);
		case ($urandom_range(7))
			0: m = '0;
			1: m = 15'h7FFF;
			default: m = 15'(rand_mag(15));
		endcase
		return {junk, m};
	endfunction

	// mostly small motion from the last count, now and then a jump anywhere
	function automatic logic [COUNT_W-1:0] next_count(logic [COUNT_W-1:0] last);
		case ($urandom_range(9))
			0, 9:    return $urandom;
			1, 2, 3: return last + $urandom_range(32) - 16;
			4, 5, 6: return last + $urandom_range(2000) - 1000;
			default: return last + $urandom_range(200000) - 100000;
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_reset_defaults();
		push_counts(0, 0);
		push_counts(12, 20);
		push_counts(-5, -40);
		settle();
	endtask

	task automatic test_count_wrap();
		write_reg(REG_PERIOD, 24'd1);
		write_reg(REG_PWM_LIMIT, 24'h007FFF);
		write_reg(REG_FWD_KP, 24'd4096);
		write_reg(REG_ROT_KP, 24'd4096);
		push_counts(32'h7FFFFFFF, 32'h80000000);
		push_counts(32'h80000000, 32'h7FFFFFFF);
		push_counts(32'h80000000, 32'h7FFFFFFF);
		push_counts(32'h00000000, 32'h00000000);
		push_counts(32'h7FFFFFFF, 32'h80000001);
		settle();
	endtask

	task automatic test_zero_period();
		// only the low 16 bits count, so this writes a zero period
		write_reg(REG_PERIOD, 24'hAB0000);
		write_reg(REG_FWD_KD, 24'd4096);
		write_reg(REG_ROT_KD, 24'd2048);
		push_counts(3, 7);
		push_counts(13, -3);
		push_counts(13, -3);
		settle();
		write_reg(REG_PERIOD, 24'h00FFFF);
		push_counts(1000, 2000);
		settle();
	endtask

	task automatic test_gain_extremes();
		write_reg(REG_FWD_KP, 24'hFFFFFF);
		write_reg(REG_FWD_KD, 24'hFFFFFF);
		write_reg(REG_ROT_KP, 24'hFFFFFF);
		write_reg(REG_ROT_KD, 24'hFFFFFF);
		write_reg(REG_TGT_FWD, 24'h7FFFFF);
		write_reg(REG_TGT_ROT, 24'h800000);
		write_reg(REG_PWM_LIMIT, 24'hFF8000);
		push_counts(0, 0);
		push_counts(5, 5);
		settle();
		write_reg(REG_PWM_LIMIT, 24'h007FFF);
		write_reg(REG_TGT_FWD, 24'h800000);
		write_reg(REG_TGT_ROT, 24'h7FFFFF);
		push_counts(-100, 100);
		push_counts(-100, 100);
		settle();
		write_reg(REG_FWD_KP, 24'd0);
		write_reg(REG_FWD_KD, 24'd0);
		write_reg(REG_ROT_KP, 24'd0);
		write_reg(REG_ROT_KD, 24'd0);
		push_counts(-90, 120);
		push_counts(-60, 150);
		settle();
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int s = 0; s < SEGMENTS; s++) begin
			write_reg(REG_TGT_FWD, rand_target());
			write_reg(REG_TGT_ROT, rand_target());
			write_reg(REG_FWD_KP, rand_gain());
			write_reg(REG_FWD_KD, rand_gain());
			write_reg(REG_ROT_KP, rand_gain());
			write_reg(REG_ROT_KD, rand_gain());
			write_reg(REG_PERIOD, rand_period());
			write_reg(REG_PWM_LIMIT, rand_limit());
			for (int k = 0; k < SEG_ITEMS; k++) begin
				push_counts(next_count(sent_left), next_count(sent_right));
			end
			settle();
		end
	endtask

	initial begin
		load_reset_values();
		send_idle_pct = 23;
		recv_idle_pct = 88;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_count_wrap();
		test_zero_period();
		test_gain_extremes();
		test_random_traffic(23, 88);
		test_random_traffic(88, 23);
		test_random_traffic(0, 0);

		settle();
		repeat (80) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
